// File: rtl/core/fvn_pkg.sv
`default_nettype none
package fvn_pkg;

  localparam int OCTAVE_COUNT = 6;
  localparam int CELL_STAGES  = 8;

  localparam int IDX_W   = 12;
  localparam int SEED_W  = 32;
  localparam int AMP_W   = 40;
  localparam int GAIN_W  = 16;
  localparam int STEP_W  = 48;
  localparam int COORD_W = 64;
  localparam int HGT_W   = 44;
  localparam int CFG_W   = 48;
  localparam int CFG_IDX_W = 3;

  localparam logic [31:0] HASH_C1     = 32'd747796405;
  localparam logic [31:0] HASH_C2     = 32'd2891336453;
  localparam logic [31:0] HASH_C3     = 32'd2246822519;
  localparam logic [31:0] HASH_C4     = 32'd3266489917;
  localparam logic [63:0] GOLDEN_Q32  = 64'd2654435769;
  localparam logic [31:0] SEED_STRIDE = 32'd7919;
  localparam logic [HGT_W-1:0] HEIGHT_MAX = {HGT_W{1'b1}};
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE       = 3'd0,
    CFG_NOISE_SEED   = 3'd1,
    CFG_AMPLITUDE    = 3'd2,
    CFG_OCTAVE_GAIN  = 3'd3,
    CFG_LATTICE_STEP = 3'd4
  } cfg_index_t;

  // Per-sample data travelling from one octave cell to the next.
  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] base;
    logic [COORD_W-1:0] goff;
    logic [SEED_W-1:0]  seed;
    logic [AMP_W-1:0]   amp;
    logic [HGT_W-1:0]   sum;
  } fvn_bundle_t;

endpackage
`default_nettype wire

// File: rtl/core/fvn_if.sv
`default_nettype none
interface fvn_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] sample_index;
  modport source (output valid, output sample_index, input ready);
  modport sink (input valid, input sample_index, output ready);
endinterface

interface fvn_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] sample_echo;
  logic [43:0] height;
  modport source (output valid, output sample_echo, output height, input ready);
  modport sink (input valid, input sample_echo, input height, output ready);
endinterface
`default_nettype wire

// File: rtl/core/fvn_cell.sv
`default_nettype none
module fvn_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      adv,
  input  wire logic [15:0]               gain,
  input  wire logic                      in_vld,
  input  wire fvn_pkg::fvn_bundle_t      in_b,
  output logic                           out_vld,
  output fvn_pkg::fvn_bundle_t           out_b
);
  import fvn_pkg::*;

  logic [CELL_STAGES-1:0] vld_r;
  fvn_bundle_t            dl_r [CELL_STAGES-1];
  fvn_bundle_t            out_r;

  logic [63:0] coord_r;
  logic [31:0] sh_r;
  logic [31:0] ha2_r, hb2_r, t2_2_r, frac2_r;
  logic [31:0] ha3_r, hb3_r, t2_3_r, t2wl_r;
  logic [1:0]  wh3_r;
  logic [31:0] ha4_r, hb4_r, s4_r;
  logic [31:0] a5_r, diff5_r, s5_r;
  logic        ge5_r;
  logic [31:0] v6_r;
  logic [55:0] phi_r, plo_r;

  logic [31:0] xa3, xb3, xa4, xb4, a5, b5, prod6, v6;
  logic [33:0] w3, s4w;
  logic [56:0] contrib_w;
  logic [44:0] sum_w;
  logic [HGT_W-1:0] sum_sat;

  always_comb begin
    xa3 = ha2_r ^ (ha2_r >> 15);
    xb3 = hb2_r ^ (hb2_r >> 15);
    w3  = {2'b11, 32'd0} - {1'b0, frac2_r, 1'b0};
    xa4 = ha3_r ^ (ha3_r >> 13);
    xb4 = hb3_r ^ (hb3_r >> 13);
    s4w = 34'(t2_3_r) * 34'(wh3_r) + 34'(t2wl_r);
    a5  = ha4_r ^ (ha4_r >> 16);
    b5  = hb4_r ^ (hb4_r >> 16);
    prod6 = 32'((64'(diff5_r) * 64'(s5_r)) >> 32);
    v6  = ge5_r ? a5_r + prod6 : a5_r - prod6;
    contrib_w = (57'(phi_r) + 57'(plo_r >> 16)) >> 16;
    sum_w = 45'(dl_r[CELL_STAGES-2].sum) + 45'(contrib_w[AMP_W-1:0]);
    sum_sat = sum_w[HGT_W] ? HEIGHT_MAX : sum_w[HGT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[CELL_STAGES-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dl_r[0] <= in_b;
      for (int k = 1; k < CELL_STAGES - 1; k++) begin
        dl_r[k] <= dl_r[k-1];
      end
      coord_r <= in_b.base + in_b.goff;
      sh_r    <= 32'(in_b.seed * HASH_C2);
      // The next lattice point only adds one multiplier constant to the hash sum.
      ha2_r   <= 32'(coord_r[63:32] * HASH_C1) + sh_r;
      hb2_r   <= 32'(coord_r[63:32] * HASH_C1) + sh_r + HASH_C1;
      t2_2_r  <= 32'((64'(coord_r[31:0]) * 64'(coord_r[31:0])) >> 32);
      frac2_r <= coord_r[31:0];
      ha3_r   <= 32'(xa3 * HASH_C3);
      hb3_r   <= 32'(xb3 * HASH_C3);
      t2_3_r  <= t2_2_r;
      wh3_r   <= w3[33:32];
      t2wl_r  <= 32'((64'(t2_2_r) * 64'(w3[31:0])) >> 32);
      ha4_r   <= 32'(xa4 * HASH_C4);
      hb4_r   <= 32'(xb4 * HASH_C4);
      s4_r    <= s4w[31:0];
      a5_r    <= a5;
      ge5_r   <= b5 >= a5;
      diff5_r <= (b5 >= a5) ? b5 - a5 : a5 - b5;
      s5_r    <= s4_r;
      v6_r    <= v6;
      phi_r   <= 56'(dl_r[CELL_STAGES-3].amp) * 56'(v6_r[31:16]);
      plo_r   <= 56'(dl_r[CELL_STAGES-3].amp) * 56'(v6_r[15:0]);
      out_r.idx  <= dl_r[CELL_STAGES-2].idx;
      out_r.base <= dl_r[CELL_STAGES-2].base << 1;
      out_r.goff <= dl_r[CELL_STAGES-2].goff + GOLDEN_Q32;
      out_r.seed <= dl_r[CELL_STAGES-2].seed + SEED_STRIDE;
      out_r.amp  <= 40'((56'(dl_r[CELL_STAGES-2].amp) * 56'(gain)) >> 16);
      out_r.sum  <= sum_sat;
    end
  end

  assign out_vld = vld_r[CELL_STAGES-1];
  assign out_b   = out_r;

endmodule
`default_nettype wire

// File: rtl/core/fractal_value_noise_profile.sv
`default_nettype none
// One-dimensional fractal value-noise height generator. Each request carries a sample
// index and yields one result with that index and its saturated Q28.16 height. The
// block takes one request per clock unless the output stalls, and keeps up to 49 in
// flight: an input stage forms index times lattice step, then six identical octave
// cells of eight stages each hash, blend, scale and accumulate. A stalled output holds
// the whole pipeline. Write the configuration only while idle.
module fractal_value_noise_profile (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  fvn_in_if.sink           in_ch,
  fvn_out_if.source        out_ch
);
  import fvn_pkg::*;

  logic              enable_r;
  logic [SEED_W-1:0] noise_seed_r;
  logic [AMP_W-1:0]  amplitude_r;
  logic [GAIN_W-1:0] octave_gain_r;
  logic [STEP_W-1:0] lattice_step_r;

  logic        adv;
  logic        in0_vld_r;
  fvn_bundle_t in0_r;
  logic        ch_vld [OCTAVE_COUNT+1];
  fvn_bundle_t ch_b   [OCTAVE_COUNT+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r       <= 1'b0;
      noise_seed_r   <= '0;
      amplitude_r    <= '0;
      octave_gain_r  <= GAIN_RESET;
      lattice_step_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE:       enable_r       <= cfg_data[0];
        CFG_NOISE_SEED:   noise_seed_r   <= cfg_data[SEED_W-1:0];
        CFG_AMPLITUDE:    amplitude_r    <= cfg_data[AMP_W-1:0];
        CFG_OCTAVE_GAIN:  octave_gain_r  <= cfg_data[GAIN_W-1:0];
        CFG_LATTICE_STEP: lattice_step_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv         = !ch_vld[OCTAVE_COUNT] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in0_vld_r <= 1'b0;
    end else if (adv) begin
      in0_vld_r <= in_ch.valid;
    end
  end

  // A zero amplitude makes every octave contribute nothing when disabled.
  always_ff @(posedge clk) begin
    if (adv) begin
      in0_r.idx  <= in_ch.sample_index;
      in0_r.base <= 64'(60'(in_ch.sample_index) * 60'(lattice_step_r));
      in0_r.goff <= '0;
      in0_r.seed <= noise_seed_r;
      in0_r.amp  <= enable_r ? amplitude_r : '0;
      in0_r.sum  <= '0;
    end
  end

  assign ch_vld[0] = in0_vld_r;
  assign ch_b[0]   = in0_r;

  for (genvar o = 0; o < OCTAVE_COUNT; o++) begin : g_oct
    fvn_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .gain    (octave_gain_r),
      .in_vld  (ch_vld[o]),
      .in_b    (ch_b[o]),
      .out_vld (ch_vld[o+1]),
      .out_b   (ch_b[o+1])
    );
  end

  assign out_ch.valid       = ch_vld[OCTAVE_COUNT];
  assign out_ch.sample_echo = ch_b[OCTAVE_COUNT].idx;
  assign out_ch.height      = ch_b[OCTAVE_COUNT].sum;

endmodule
`default_nettype wire

// File: verif/tb_fractal_value_noise_profile.sv
`timescale 1ns / 1ps
module tb_fractal_value_noise_profile;
  import fvn_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int PIPE_DEPTH = 49;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [IDX_W-1:0] echo;
    logic [HGT_W-1:0] height;
  } height_rec_t;

  class height_scoreboard;
    logic             en;
    logic [31:0]      seed;
    logic [AMP_W-1:0] amp;
    logic [15:0]      gain;
    logic [STEP_W-1:0] step;
    height_rec_t      pending[$];
    int               mismatches;

    function new();
      en = 1'b0; seed = '0; amp = '0; gain = GAIN_RESET; step = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] index, logic [47:0] data);
      case (index)
        CFG_ENABLE:       en = data[0];
        CFG_NOISE_SEED:   seed = data[31:0];
        CFG_AMPLITUDE:    amp = data[AMP_W-1:0];
        CFG_OCTAVE_GAIN:  gain = data[15:0];
        CFG_LATTICE_STEP: step = data[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] mix32(logic [31:0] p, logic [31:0] s);
      logic [31:0] h;
      h = p * HASH_C1 + s * HASH_C2;
      h = h ^ (h >> 15);
      h = h * HASH_C3;
      h = h ^ (h >> 13);
      h = h * HASH_C4;
      h = h ^ (h >> 16);
      return h;
    endfunction

    function logic [63:0] blend(logic [63:0] coord, logic [31:0] s);
      logic [31:0] pt, t;
      logic [63:0] a, b, t2, w, sw;
      pt = coord[63:32];
      t = coord[31:0];
      a = mix32(pt, s);
      b = mix32(pt + 32'd1, s);
      t2 = ({32'd0, t} * {32'd0, t}) >> 32;
      w = (64'd3 << 32) - ({32'd0, t} << 1);
      sw = t2 * (w >> 32) + ((t2 * {32'd0, w[31:0]}) >> 32);
      if (b >= a) return a + (((b - a) * sw) >> 32);
      return a - (((a - b) * sw) >> 32);
    endfunction

    function height_rec_t predict(logic [IDX_W-1:0] idx);
      height_rec_t r;
      logic [63:0] base, coord, v, a, sum;
      logic [31:0] s;
      r.echo = idx;
      sum = 0;
      if (en) begin
        base = {52'd0, idx} * {16'd0, step};
        a = {24'd0, amp};
        for (int o = 0; o < OCTAVE_COUNT; o++) begin
          coord = (base << o) + 64'(o) * GOLDEN_Q32;
          s = seed + 32'(o) * SEED_STRIDE;
          v = blend(coord, s);
          sum += (a * (v >> 16) + ((a * (v & 64'hFFFF)) >> 16)) >> 16;
          if (sum > {20'd0, HEIGHT_MAX}) sum = {20'd0, HEIGHT_MAX};
          a = (a * {48'd0, gain}) >> 16;
        end
      end
      r.height = sum[HGT_W-1:0];
      return r;
    endfunction

    function void note_request(logic [IDX_W-1:0] idx);
      pending.push_back(predict(idx));
    endfunction

    function void check_result(logic [IDX_W-1:0] echo, logic [HGT_W-1:0] height);
      height_rec_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: echo %0d height %h", echo, height);
        return;
      end
      e = pending.pop_front();
      if (e.echo !== echo || e.height !== height) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected echo %0d height %h, got echo %0d height %h",
                   e.echo, e.height, echo, height);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;
  fvn_in_if  in_ch ();
  fvn_out_if out_ch ();

  fractal_value_noise_profile DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  height_scoreboard sb = new();
  bit  steady = 1'b0;
  bit  hold_request = 1'b0;
  int  cycles = 0;

  always #2 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample_index = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.sample_echo, out_ch.height);

  // Result side: a random stall before each result unless steady, or one long stall on demand.
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        out_ch.ready = 1'b0;
        for (int i = 0; i < 200; i++) @(negedge clk);
        hold_request = 1'b0;
      end
      n = steady ? 0 : $urandom_range(0, 6);
      if (n > 0) begin
        out_ch.ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  task automatic send_request(logic [IDX_W-1:0] idx);
    int n;
    n = steady ? 0 : $urandom_range(0, 6);
    if (n > 0) begin
      in_ch.valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.sample_index = idx;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(idx);
    @(negedge clk);
  endtask

  // Drops valid and waits for every outstanding result before touching registers.
  task automatic drain();
    in_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] index, logic [47:0] data);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_data = data;
    sb.set_reg(index, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_all(logic en, logic [31:0] seed, logic [47:0] amp,
                           logic [47:0] gain, logic [47:0] step);
    write_reg(CFG_ENABLE, {47'h0, en});
    write_reg(CFG_NOISE_SEED, {16'h0, seed});
    write_reg(CFG_AMPLITUDE, amp);
    write_reg(CFG_OCTAVE_GAIN, gain);
    write_reg(CFG_LATTICE_STEP, step);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  initial begin
    logic [47:0] amp, gain, step;
    logic [31:0] seed;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset values: disabled, so the height is zero but the index still echoes.
    send_request(12'd0);
    send_request(12'd4095);
    send_request(12'd1234);
    drain();

    // Writes to spare indexes must leave the registers alone.
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, '1);
    send_request(12'd77);
    drain();

    // Everything at its top value; bits above each register are dropped.
    write_all(1'b1, 32'hFFFFFFFF, '1, '1, '1);
    write_reg(CFG_ENABLE, '1);
    send_request(12'd0);
    send_request(12'd4095);
    send_request(12'd1);
    send_request(12'd2048);
    drain();
    write_all(1'b1, 32'h0, 48'hFF_FFFF_FFFF, 48'h0, 48'h1);
    send_request(12'd0);
    send_request(12'd4095);
    send_request(12'd3);
    drain();
    write_all(1'b1, 32'h12345678, 48'h1_0000, 48'h8000, 48'h0);
    send_request(12'd0);
    send_request(12'd4095);
    drain();
    write_all(1'b0, 32'hDEADBEEF, '1, '1, '1);
    send_request(12'd4095);
    send_request(12'd2);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      seed = $urandom();
      amp = (ph == 3) ? '1 : rand48();
      gain = (ph == 4) ? '1 : (ph == 5) ? '0 : rand48();
      step = (ph == 6) ? '1 : ($urandom_range(0, 1) ? rand48() : rand48() >> 24);
      write_all((ph == 7) ? 1'b0 : 1'b1, seed, amp, gain, step);
      steady = (ph == 1);
      if (ph == 2) hold_request = 1'b1;
      for (int i = 0; i < 150; i++)
        send_request(12'($urandom()));
      drain();
    end
    steady = 1'b0;

    repeat (PIPE_DEPTH + 10) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule

// File: fractal_value_noise_profile.f
rtl/core/fvn_pkg.sv
rtl/core/fvn_if.sv
rtl/core/fvn_cell.sv
rtl/core/fractal_value_noise_profile.sv
verif/tb_fractal_value_noise_profile.sv
